### rtl/core/serial_line_editor_assert.svh
// assertion macros for the serial line editor checker
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("serial line editor assertion failed");

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("serial line editor assertion failed");

`endif

### rtl/core/sle_pkg.sv
// shared constants, types and helper functions of the serial line editor
// no dependencies
`timescale 1ns / 1ps

package sle_pkg;

    // line store geometry
    localparam int LINE_LEN  = 32;
    localparam int CNT_W     = $clog2(LINE_LEN);
    localparam int MEM_AW    = CNT_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    // control characters
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_UP  = 8'h41;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // output value source
    typedef enum logic [1:0] {
        SRC_ECHO,
        SRC_MEM,
        SRC_ZERO
    } t_src;

    // fixed echo sequences
    typedef enum logic [1:0] {
        SEQ_BS,
        SEQ_CRLF,
        SEQ_CHAR,
        SEQ_FULL
    } t_seq;

    // action decoded from an accepted byte
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_RECALL,
        ACT_BS,
        ACT_CR,
        ACT_CR_EMPTY,
        ACT_CHAR,
        ACT_FULL
    } t_act;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_WALK,
        S_END
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       load;
        t_kind      kind;
        t_src       src;
        logic       last;
        t_seq       seq;
        logic [1:0] step;
        logic       idx_inc;
        logic       finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_act act;
        logic out_free;
        logic walk_last;
        logic walk_hist;
    } t_stat;

    // final step index of an echo sequence
    function automatic logic [1:0] seq_last_step(input t_seq seq);
        logic [1:0] s;
        case (seq)
            SEQ_BS:   s = 2'd2;
            SEQ_CRLF: s = 2'd1;
            SEQ_CHAR: s = 2'd0;
            SEQ_FULL: s = 2'd3;
            default:  s = 2'd0;
        endcase
        return s;
    endfunction

    // character of an echo sequence at a given step
    function automatic logic [7:0] echo_char(input t_seq seq, input logic [1:0] step,
                                             input logic [7:0] b);
        logic [7:0] ch;
        case (seq)
            SEQ_BS:   ch = (step == 2'd1) ? CH_SP : CH_BS;
            SEQ_CRLF: ch = (step == 2'd0) ? CH_CR : CH_LF;
            SEQ_CHAR: ch = b;
            SEQ_FULL: begin
                case (step)
                    2'd0:    ch = b;
                    2'd2:    ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            end
            default:  ch = b;
        endcase
        return ch;
    endfunction

endpackage

### rtl/core/sle_if.sv
// request channel interfaces of the serial line editor
// depends on nothing; payload widths follow the byte and result fields
`timescale 1ns / 1ps

// received byte channel
interface sle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

### rtl/core/serial_line_editor.sv
// top level of the serial line editor: controller plus datapath
// depends on sle_pkg, sle_if, sle_ctrl and sle_dpath
//
// Usage: bytes from a serial receiver enter on i_in (valid/ready, rx_byte).
// Each accepted byte yields zero or more results on o_out (kind, value,
// last): echo bytes (kind 0), completed line bytes (kind 1) and an end of
// line marker (kind 2). last marks the final result of one input byte.
// A byte is accepted while the controller is idle; its first result passes
// the state register and then the output register; results leave one per
// cycle while the receiver takes them. A byte with results holds the block
// until its last one is loaded: fixed echoes take one step each, and the
// line or history is walked one entry per cycle through the registered
// read port unless the output stalls; a full line gives 36 results. Bytes
// that cause no result are taken back to back. The next byte may be
// accepted while the last result still waits in the output register.
// Reset clears the line count, the history length, the escape skip and the
// output valid; the line and history memory need no clearing pass.
// When the receiver stalls, the output register holds and the sequencer
// waits; no result is lost.
`timescale 1ns / 1ps

module serial_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sle_in_if.sink     i_in,
    sle_out_if.source  o_out
);

    sle_pkg::t_cmd  cmd;
    sle_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;
    logic [1:0]     out_kind;
    logic [7:0]     out_value;
    logic           out_last;

    // sequencing
    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage and output
    sle_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_in.rx_byte),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_kind      (out_kind),
        .o_value     (out_value),
        .o_last      (out_last)
    );

    // channel hookup
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.kind  = out_kind;
    assign o_out.value = out_value;
    assign o_out.last  = out_last;

endmodule

### rtl/core/sle_ctrl.sv
// controller state machine of the serial line editor
// depends on sle_pkg; drives the datapath through t_cmd, reads t_stat
`timescale 1ns / 1ps

module sle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd  o_cmd
);

    sle_pkg::t_state r_state, n_state;
    sle_pkg::t_seq   r_seq, n_seq;
    logic [1:0]      r_step, n_step;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::S_IDLE;
            r_seq   <= sle_pkg::SEQ_CHAR;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_seq   <= n_seq;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_seq         = r_seq;
        n_step        = r_step;
        o_in_ready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.kind    = sle_pkg::KIND_ECHO;
        o_cmd.src     = sle_pkg::SRC_ECHO;
        o_cmd.last    = 1'b0;
        o_cmd.seq     = r_seq;
        o_cmd.step    = r_step;
        o_cmd.idx_inc = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            sle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step       = 2'd0;
                    case (i_stat.act)
                        sle_pkg::ACT_RECALL: n_state = sle_pkg::S_WALK;
                        sle_pkg::ACT_BS: begin
                            n_state = sle_pkg::S_ECHO;
                            n_seq   = sle_pkg::SEQ_BS;
                        end
                        sle_pkg::ACT_CR: begin
                            n_state = sle_pkg::S_ECHO;
                            n_seq   = sle_pkg::SEQ_CRLF;
                        end
                        sle_pkg::ACT_CR_EMPTY: n_state = sle_pkg::S_END;
                        sle_pkg::ACT_CHAR: begin
                            n_state = sle_pkg::S_ECHO;
                            n_seq   = sle_pkg::SEQ_CHAR;
                        end
                        sle_pkg::ACT_FULL: begin
                            n_state = sle_pkg::S_ECHO;
                            n_seq   = sle_pkg::SEQ_FULL;
                        end
                        default: n_state = sle_pkg::S_IDLE;
                    endcase
                end
            end
            // fixed echo characters, one per result
            sle_pkg::S_ECHO: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (r_step == sle_pkg::seq_last_step(r_seq)) begin
                        if (r_seq inside {sle_pkg::SEQ_BS, sle_pkg::SEQ_CHAR}) begin
                            o_cmd.last = 1'b1;
                            n_state    = sle_pkg::S_IDLE;
                        end else begin
                            n_state = sle_pkg::S_WALK;
                        end
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            // walk the line or the history, one entry per result
            sle_pkg::S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.src     = sle_pkg::SRC_MEM;
                    o_cmd.kind    = i_stat.walk_hist ? sle_pkg::KIND_ECHO : sle_pkg::KIND_LINE;
                    o_cmd.last    = i_stat.walk_hist && i_stat.walk_last;
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = i_stat.walk_hist ? sle_pkg::S_IDLE : sle_pkg::S_END;
                    end
                end
            end
            // end marker and history update
            sle_pkg::S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.src    = sle_pkg::SRC_ZERO;
                    o_cmd.kind   = sle_pkg::KIND_END;
                    o_cmd.last   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = sle_pkg::S_IDLE;
                end
            end
            default: n_state = sle_pkg::S_IDLE;
        endcase
    end

endmodule

### rtl/core/sle_dpath.sv
// datapath of the serial line editor: byte decode, counters, line and
// history memory, output register; depends on sle_pkg
`timescale 1ns / 1ps

module sle_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_rx_byte,
    input  sle_pkg::t_cmd  i_cmd,
    output sle_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_value,
    output logic           o_last
);

    localparam int CW = sle_pkg::CNT_W;
    localparam int AW = sle_pkg::MEM_AW;

    // two banks: one holds the line, the other the history
    logic [7:0] mem [0:sle_pkg::MEM_DEPTH-1];

    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_hist_len, n_hist_len;
    logic [1:0]     r_skip, n_skip;
    logic           r_line_bank, n_line_bank;
    logic [CW-1:0]  r_idx, n_idx;
    logic           r_walk_hist, n_walk_hist;
    logic [7:0]     r_byte;
    logic [7:0]     r_rd_data;
    logic           r_out_valid, n_out_valid;
    sle_pkg::t_kind r_kind;
    logic [7:0]     r_value, n_value;
    logic           r_last;

    sle_pkg::t_act  act;
    logic [1:0]     acc_skip;
    logic [CW-1:0]  acc_count;
    logic           acc_wr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic [AW-1:0]  rd_addr;
    logic           keep_hist;

    // decode the byte offered on the input
    always_comb begin
        act       = sle_pkg::ACT_NONE;
        acc_skip  = r_skip;
        acc_count = r_count;
        acc_wr    = 1'b0;
        if (r_skip != 2'd0) begin
            acc_skip = r_skip - 2'd1;
            if (r_skip == 2'd1 && i_rx_byte == sle_pkg::CH_UP && r_count == '0) begin
                acc_count = r_hist_len;
                if (r_hist_len != '0) begin
                    act = sle_pkg::ACT_RECALL;
                end
            end
        end else if (i_rx_byte == sle_pkg::CH_ESC) begin
            acc_skip = 2'd2;
        end else if (i_rx_byte == sle_pkg::CH_BS) begin
            if (r_count != '0) begin
                act       = sle_pkg::ACT_BS;
                acc_count = r_count - CW'(1);
            end
        end else if (i_rx_byte == sle_pkg::CH_CR) begin
            act = (r_count != '0) ? sle_pkg::ACT_CR : sle_pkg::ACT_CR_EMPTY;
        end else if (r_count < CW'(sle_pkg::LINE_LEN - 1)) begin
            acc_wr    = 1'b1;
            acc_count = r_count + CW'(1);
            act       = (r_count == CW'(sle_pkg::LINE_LEN - 2)) ? sle_pkg::ACT_FULL
                                                               : sle_pkg::ACT_CHAR;
        end
    end

    // next values of counters and walk index
    always_comb begin
        keep_hist   = i_cmd.finish && (r_count != '0);
        n_count     = r_count;
        n_hist_len  = r_hist_len;
        n_line_bank = r_line_bank;
        n_skip      = r_skip;
        n_idx       = r_idx;
        n_walk_hist = r_walk_hist;
        if (i_cmd.accept) begin
            n_count     = acc_count;
            n_skip      = acc_skip;
            n_idx       = '0;
            n_walk_hist = (act == sle_pkg::ACT_RECALL);
        end else begin
            if (i_cmd.idx_inc) begin
                n_idx = r_idx + CW'(1);
            end
            if (i_cmd.finish) begin
                n_count = '0;
            end
            if (keep_hist) begin
                n_hist_len  = r_count;
                n_line_bank = ~r_line_bank;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hist_len  <= '0;
            r_skip      <= 2'd0;
            r_line_bank <= 1'b0;
            r_idx       <= '0;
            r_walk_hist <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_hist_len  <= n_hist_len;
            r_skip      <= n_skip;
            r_line_bank <= n_line_bank;
            r_idx       <= n_idx;
            r_walk_hist <= n_walk_hist;
            r_out_valid <= n_out_valid;
        end
    end

    // memory write: new byte on accept, recalled byte during the history walk
    always_comb begin
        wr_en   = (i_cmd.accept && acc_wr) ||
                  (i_cmd.load && i_cmd.src == sle_pkg::SRC_MEM && r_walk_hist);
        wr_addr = i_cmd.accept ? {r_line_bank, r_count} : {r_line_bank, r_idx};
        wr_data = i_cmd.accept ? i_rx_byte : r_rd_data;
    end

    // read one entry ahead so r_rd_data always holds the current index
    assign rd_addr = {(n_walk_hist ? ~r_line_bank : r_line_bank), n_idx};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // byte latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_rx_byte;
        end
    end

    // output register
    always_comb begin
        case (i_cmd.src)
            sle_pkg::SRC_ECHO: n_value = sle_pkg::echo_char(i_cmd.seq, i_cmd.step, r_byte);
            sle_pkg::SRC_MEM:  n_value = r_rd_data;
            default:           n_value = 8'h00;
        endcase
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_cmd.kind;
            r_value <= n_value;
            r_last  <= i_cmd.last;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.act       = act;
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.walk_last = (r_idx == r_count - CW'(1));
        o_stat.walk_hist = r_walk_hist;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

### rtl/core/sle_checker.sv
// port-level checks of the serial line editor result channel
// depends on sle_pkg and serial_line_editor_assert.svh; bound to the top level
`timescale 1ns / 1ps
`include "serial_line_editor_assert.svh"

module sle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_value,
    input logic       i_out_last
);

    logic [10:0] out_payload;

    // whole result payload
    assign out_payload = {i_out_kind, i_out_value, i_out_last};

    // a stalled result holds
    `SLE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(out_payload))

    // end marker closes the request's results
    `SLE_ASSERT_IMPL(a_end_last, i_out_valid && i_out_kind == sle_pkg::KIND_END, i_out_last)

    // end marker carries zero
    `SLE_ASSERT_IMPL(a_end_zero, i_out_valid && i_out_kind == sle_pkg::KIND_END, i_out_value == 8'h00)

    // line bytes never carry last; the end marker closes the line
    `SLE_ASSERT_IMPL(a_line_not_last, i_out_valid && i_out_kind == sle_pkg::KIND_LINE, !i_out_last)

endmodule

bind serial_line_editor sle_checker u_sle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last)
);
